// ===== hw/rtl/tdsr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the tilt drive steering regulator.
// No dependencies; every other file of the block refers to this package by scoped names.
package tdsr_pkg;

  localparam int KP_W       = 16;
  localparam int KD_W       = 4;
  localparam int STOP_W     = 12;
  localparam int ERR_W      = 16;
  localparam int SPD_W      = 16;
  localparam int CMD_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SAT_IN_W   = 40;

  localparam logic [KP_W-1:0]   KP_RESET         = 16'd2000;
  localparam logic [KD_W-1:0]   KD_FWD_RESET     = 4'd1;
  localparam logic [KD_W-1:0]   KD_BWD_RESET     = 4'd2;
  localparam logic [STOP_W-1:0] SIDE_LIMIT_RESET = 12'd300;
  localparam logic [STOP_W-1:0] REAR_LIMIT_RESET = 12'd40;

  localparam logic signed [SPD_W-1:0] SPD_MAX = 16'sh7fff;
  localparam logic signed [SPD_W-1:0] SPD_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP         = 3'd0,
    REG_KD_FWD     = 3'd1,
    REG_KD_BWD     = 3'd2,
    REG_SIDE_LIMIT = 3'd3,
    REG_REAR_LIMIT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [KP_W-1:0]   kp_gain;
    logic [KD_W-1:0]   kd_forward;
    logic [KD_W-1:0]   kd_backward;
    logic [STOP_W-1:0] side_limit;
    logic [STOP_W-1:0] rear_limit;
  } cfg_t;

  // Clamp a wide signed value into the 16-bit speed range.
  function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SPD_W-1:0] r;
    if (v > SAT_IN_W'(SPD_MAX)) begin
      r = SPD_MAX;
    end else if (v < SAT_IN_W'(SPD_MIN)) begin
      r = SPD_MIN;
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tdsr_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the regulator: one tick with tilt error and six proximity readings.
// Depends on tdsr_pkg for field widths.
interface tdsr_in_if #(
  parameter int SENSOR_BITS = 12
);
  logic                              valid;
  logic                              ready;
  logic                              sample_ready;
  logic signed [tdsr_pkg::ERR_W-1:0] tilt_error;
  logic [SENSOR_BITS-1:0]            front_left_prox;
  logic [SENSOR_BITS-1:0]            front_right_prox;
  logic [SENSOR_BITS-1:0]            left_prox;
  logic [SENSOR_BITS-1:0]            right_prox;
  logic [SENSOR_BITS-1:0]            back_left_prox;
  logic [SENSOR_BITS-1:0]            back_right_prox;

  modport source (
    output valid, sample_ready, tilt_error, front_left_prox, front_right_prox,
           left_prox, right_prox, back_left_prox, back_right_prox,
    input  ready
  );
  modport sink (
    input  valid, sample_ready, tilt_error, front_left_prox, front_right_prox,
           left_prox, right_prox, back_left_prox, back_right_prox,
    output ready
  );
endinterface

// ===== hw/rtl/tdsr_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the regulator: one motor command per tick.
// Depends on tdsr_pkg for field widths.
interface tdsr_out_if;
  logic                              valid;
  logic                              ready;
  logic                              motor_write;
  logic signed [tdsr_pkg::CMD_W-1:0] left_speed;
  logic signed [tdsr_pkg::CMD_W-1:0] right_speed;

  modport source (output valid, motor_write, left_speed, right_speed, input ready);
  modport sink (input valid, motor_write, left_speed, right_speed, output ready);
endinterface

// ===== hw/rtl/tdsr_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel of the regulator: register index and write data.
// Depends on tdsr_pkg for field widths.
interface tdsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tdsr_pkg::CFG_IDX_W-1:0]    index;
  logic [tdsr_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== hw/rtl/tilt_drive_steering_regulator_top.sv =====
`timescale 1ns / 1ps
// Top level of the tilt drive steering regulator: input register, compute, result register.
// Depends on tdsr_pkg, the three channel interfaces, tdsr_cfg_regs and tdsr_steer.

// The regulator turns one 100 Hz tick into one motor command. A tick whose
// sample_ready bit is set recomputes the held base speed from the tilt error
// times kp_gain (truncated toward zero, saturated to 16 bits) and, while the
// robot moves, adds a derivative steering correction taken from the larger
// front-diagonal reading, which is dropped if it would turn toward a side wall
// whose reading is above the side limit. Right speed is base minus correction,
// left speed is base plus correction. On every tick, if both rear readings
// exceed the rear limit while the held speed is negative, both motors get zero
// with motor_write set. One tick is accepted every clock cycle unless the
// result channel stalls; a tick transfers into the input register, passes
// through one combinational stage (the 16 by 16 kp multiplier followed by
// the correction add) and is written into the result register, which offers
// its command. A stalled result channel holds the result register and the
// input register behind it; back-pressure reaches the input channel only when
// both are full. Configuration writes are taken every cycle and take effect
// from the next cycle on, also for a tick already waiting in the input register.
module tilt_drive_steering_regulator_top #(
  parameter int SENSOR_BITS     = 12,
  parameter int ERROR_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  tdsr_in_if.sink     in_ch,
  tdsr_out_if.source  out_ch,
  tdsr_cfg_if.sink    cfg_ch
);

  localparam int PROD_W = tdsr_pkg::KP_W + 1 + tdsr_pkg::ERR_W;
  localparam int CMP_W  = (SENSOR_BITS > tdsr_pkg::STOP_W) ? SENSOR_BITS : tdsr_pkg::STOP_W;
  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << ERROR_FRAC_BITS) - 64'd1);

  tdsr_pkg::cfg_t regs;

  tdsr_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .regs  (regs)
  );

  // Input register.
  logic                               stg_v_r;
  logic                               stg_ready_r;
  logic signed [tdsr_pkg::ERR_W-1:0]  stg_tilt_r;
  logic [SENSOR_BITS-1:0]             stg_fl_r;
  logic [SENSOR_BITS-1:0]             stg_fr_r;
  logic [SENSOR_BITS-1:0]             stg_sl_r;
  logic [SENSOR_BITS-1:0]             stg_sr_r;
  logic [SENSOR_BITS-1:0]             stg_bl_r;
  logic [SENSOR_BITS-1:0]             stg_br_r;

  // Regulator state.
  logic signed [tdsr_pkg::SPD_W-1:0]  held_r;
  logic signed [tdsr_pkg::SPD_W-1:0]  held_nxt;
  logic [SENSOR_BITS-1:0]             prev_fl_r;
  logic [SENSOR_BITS-1:0]             prev_fr_r;

  // Result register.
  logic                               out_v_r;
  logic                               write_r;
  logic signed [tdsr_pkg::CMD_W-1:0]  left_r;
  logic signed [tdsr_pkg::CMD_W-1:0]  right_r;
  logic                               write_nxt;
  logic signed [tdsr_pkg::CMD_W-1:0]  left_nxt;
  logic signed [tdsr_pkg::CMD_W-1:0]  right_nxt;

  logic                               adv;
  logic                               in_xfer;
  logic                               tick_done;
  logic signed [PROD_W-1:0]           prod;
  logic signed [PROD_W-1:0]           biased;
  logic signed [PROD_W-1:0]           quot;
  logic signed [tdsr_pkg::SPD_W-1:0]  base;
  logic                               moving_fwd;
  logic                               moving_bwd;
  logic signed [tdsr_pkg::SPD_W-1:0]  corr;
  logic                               rear_stop;

  // The compute stage may move on when the result register is empty or is being taken.
  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !stg_v_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign tick_done    = stg_v_r && adv;

  // Base speed: exact product, divide by 2^frac truncating toward zero, saturate.
  assign prod   = PROD_W'($signed({1'b0, regs.kp_gain})) * PROD_W'(stg_tilt_r);
  assign biased = prod + ((prod < 0) ? $signed(ROUND_BIAS) : '0);
  assign quot   = biased >>> ERROR_FRAC_BITS;
  assign base   = tdsr_pkg::sat_spd(tdsr_pkg::SAT_IN_W'(quot));

  assign held_nxt   = stg_ready_r ? base : held_r;
  assign moving_fwd = stg_ready_r && (held_nxt > 0);
  assign moving_bwd = stg_ready_r && (held_nxt < 0);

  tdsr_steer #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_steer (
    .moving_fwd (moving_fwd),
    .moving_bwd (moving_bwd),
    .fl         (stg_fl_r),
    .fr         (stg_fr_r),
    .sl         (stg_sl_r),
    .sr         (stg_sr_r),
    .prev_fl    (prev_fl_r),
    .prev_fr    (prev_fr_r),
    .regs       (regs),
    .corr       (corr)
  );

  // The rear stop looks at the speed as updated by this tick.
  assign rear_stop = (CMP_W'(stg_bl_r) > CMP_W'(regs.rear_limit)) &&
                     (CMP_W'(stg_br_r) > CMP_W'(regs.rear_limit)) &&
                     (held_nxt < 0);

  always_comb begin
    write_nxt = stg_ready_r;
    left_nxt  = '0;
    right_nxt = '0;
    if (stg_ready_r) begin
      left_nxt  = tdsr_pkg::CMD_W'(held_nxt) + tdsr_pkg::CMD_W'(corr);
      right_nxt = tdsr_pkg::CMD_W'(held_nxt) - tdsr_pkg::CMD_W'(corr);
    end
    if (rear_stop) begin
      write_nxt = 1'b1;
      left_nxt  = '0;
      right_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
      held_r    <= '0;
      prev_fl_r <= '0;
      prev_fr_r <= '0;
    end else begin
      if (in_ch.ready) begin
        stg_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= stg_v_r;
      end
      if (tick_done) begin
        held_r <= held_nxt;
        if (moving_fwd || moving_bwd) begin
          prev_fl_r <= stg_fl_r;
          prev_fr_r <= stg_fr_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_ready_r <= in_ch.sample_ready;
      stg_tilt_r  <= in_ch.tilt_error;
      stg_fl_r    <= in_ch.front_left_prox;
      stg_fr_r    <= in_ch.front_right_prox;
      stg_sl_r    <= in_ch.left_prox;
      stg_sr_r    <= in_ch.right_prox;
      stg_bl_r    <= in_ch.back_left_prox;
      stg_br_r    <= in_ch.back_right_prox;
    end
    if (tick_done) begin
      write_r <= write_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.motor_write = write_r;
  assign out_ch.left_speed  = left_r;
  assign out_ch.right_speed = right_r;

  // A tick leaving the compute stage always shows up in the result register.
  a_tick_lands: assert property (@(posedge clk) disable iff (!rst_n)
    tick_done |=> out_v_r)
    else $error("completed tick did not reach the result register");

  // The held speed only moves when a tick carrying a sample completes.
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(tick_done && stg_ready_r) |=> $stable(held_r))
    else $error("held speed changed without a sample tick");

  // The stored front readings only move on a completed tick while moving.
  a_prev_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(tick_done && (moving_fwd || moving_bwd)) |=> ($stable(prev_fl_r) && $stable(prev_fr_r)))
    else $error("front history changed outside a moving tick");

endmodule

// ===== hw/rtl/tdsr_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the regulator, written through the cfg channel.
// Depends on tdsr_pkg and tdsr_cfg_if.
module tdsr_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  tdsr_cfg_if.sink          cfg,
  output tdsr_pkg::cfg_t    regs
);

  tdsr_pkg::cfg_t regs_r;
  tdsr_pkg::cfg_t regs_nxt;

  assign cfg.ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg.valid) begin
      unique case (tdsr_pkg::cfg_reg_t'(cfg.index))
        tdsr_pkg::REG_KP:         regs_nxt.kp_gain     = cfg.wdata[tdsr_pkg::KP_W-1:0];
        tdsr_pkg::REG_KD_FWD:     regs_nxt.kd_forward  = cfg.wdata[tdsr_pkg::KD_W-1:0];
        tdsr_pkg::REG_KD_BWD:     regs_nxt.kd_backward = cfg.wdata[tdsr_pkg::KD_W-1:0];
        tdsr_pkg::REG_SIDE_LIMIT: regs_nxt.side_limit  = cfg.wdata[tdsr_pkg::STOP_W-1:0];
        tdsr_pkg::REG_REAR_LIMIT: regs_nxt.rear_limit  = cfg.wdata[tdsr_pkg::STOP_W-1:0];
        default:                  regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.kp_gain     <= tdsr_pkg::KP_RESET;
      regs_r.kd_forward  <= tdsr_pkg::KD_FWD_RESET;
      regs_r.kd_backward <= tdsr_pkg::KD_BWD_RESET;
      regs_r.side_limit  <= tdsr_pkg::SIDE_LIMIT_RESET;
      regs_r.rear_limit  <= tdsr_pkg::REAR_LIMIT_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== hw/rtl/tdsr_steer.sv =====
`timescale 1ns / 1ps
// Steering correction: derivative term on the larger front-diagonal reading with side veto.
// Depends on tdsr_pkg; purely combinational.
module tdsr_steer #(
  parameter int SENSOR_BITS = 12
) (
  input  logic                                moving_fwd,
  input  logic                                moving_bwd,
  input  logic [SENSOR_BITS-1:0]              fl,
  input  logic [SENSOR_BITS-1:0]              fr,
  input  logic [SENSOR_BITS-1:0]              sl,
  input  logic [SENSOR_BITS-1:0]              sr,
  input  logic [SENSOR_BITS-1:0]              prev_fl,
  input  logic [SENSOR_BITS-1:0]              prev_fr,
  input  tdsr_pkg::cfg_t                      regs,
  output logic signed [tdsr_pkg::SPD_W-1:0]   corr
);

  localparam int DW    = SENSOR_BITS + 1;
  localparam int PW    = DW + tdsr_pkg::KD_W + 1;
  localparam int CW    = PW + 1;
  localparam int CMP_W = (SENSOR_BITS > tdsr_pkg::STOP_W) ? SENSOR_BITS : tdsr_pkg::STOP_W;

  logic signed [DW-1:0]                 dl;
  logic signed [DW-1:0]                 dr;
  logic signed [DW-1:0]                 delta;
  logic signed [tdsr_pkg::KD_W:0]       kdf;
  logic signed [tdsr_pkg::KD_W:0]       kdb;
  logic signed [PW-1:0]                 prod_f;
  logic signed [PW-1:0]                 prod_b;
  logic signed [CW-1:0]                 raw;
  logic                                 left_wall;
  logic                                 right_wall;
  logic                                 veto;

  assign dl  = $signed({1'b0, fl}) - $signed({1'b0, prev_fl});
  assign dr  = $signed({1'b0, fr}) - $signed({1'b0, prev_fr});
  assign kdf = $signed({1'b0, regs.kd_forward});
  assign kdb = $signed({1'b0, regs.kd_backward});

  // Positive delta means the robot should turn so that left gets more speed.
  always_comb begin
    if (fl > fr) begin
      delta = dl;
    end else if (fr > fl) begin
      delta = -dr;
    end else begin
      delta = '0;
    end
  end

  assign prod_f = PW'(delta) * PW'(kdf);
  assign prod_b = PW'(delta) * PW'(kdb);

  // Going backward the same sensor change steers the other way.
  always_comb begin
    if (moving_fwd) begin
      raw = CW'(prod_f);
    end else if (moving_bwd) begin
      raw = -CW'(prod_b);
    end else begin
      raw = '0;
    end
  end

  assign left_wall  = CMP_W'(sl) > CMP_W'(regs.side_limit);
  assign right_wall = CMP_W'(sr) > CMP_W'(regs.side_limit);

  always_comb begin
    if (moving_fwd) begin
      veto = (left_wall && (raw < 0)) || (right_wall && (raw > 0));
    end else begin
      veto = (left_wall && (raw > 0)) || (right_wall && (raw < 0));
    end
  end

  assign corr = veto ? '0 : tdsr_pkg::sat_spd(tdsr_pkg::SAT_IN_W'(raw));

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tilt_drive_steering_regulator_top: ticks in, motor commands out.
// Depends on tdsr_pkg, the tdsr_in_if, tdsr_out_if and tdsr_cfg_if interfaces and the regulator RTL.
module tb_top;

  localparam int SENSOR_BITS     = 12;
  localparam int ERROR_FRAC_BITS = 12;
  localparam int TICKS_PER_PHASE = 50;
  localparam int RANDOM_PHASES   = 8;
  localparam int IDLE_LIMIT      = 1000;
  localparam int MAX_REPORTS     = 10;
  // Spare settle cycles after the drain; a tick passes the input and result registers first.
  localparam int SETTLE_CYCLES   = 4;

  typedef logic [SENSOR_BITS-1:0] level_t;

  typedef struct {
    logic                              sample_ready;
    logic signed [tdsr_pkg::ERR_W-1:0] tilt_error;
    level_t                            front_left;
    level_t                            front_right;
    level_t                            side_left;
    level_t                            side_right;
    level_t                            back_left;
    level_t                            back_right;
  } tick_t;

  typedef struct {
    logic                              motor_write;
    logic signed [tdsr_pkg::CMD_W-1:0] left_speed;
    logic signed [tdsr_pkg::CMD_W-1:0] right_speed;
  } motor_cmd_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tdsr_in_if #(.SENSOR_BITS(SENSOR_BITS)) in_ch ();
  tdsr_out_if out_ch ();
  tdsr_cfg_if cfg_ch ();

  tilt_drive_steering_regulator_top #(
    .SENSOR_BITS    (SENSOR_BITS),
    .ERROR_FRAC_BITS(ERROR_FRAC_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // 100 MHz clock: 5 ns high, 5 ns low.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the register file, kept in step with every accepted
  // configuration transfer. It starts at the documented reset values.
  logic [tdsr_pkg::KP_W-1:0]   kp_gain        = tdsr_pkg::KP_RESET;
  logic [tdsr_pkg::KD_W-1:0]   kd_fwd         = tdsr_pkg::KD_FWD_RESET;
  logic [tdsr_pkg::KD_W-1:0]   kd_bwd         = tdsr_pkg::KD_BWD_RESET;
  logic [tdsr_pkg::STOP_W-1:0] side_limit_lvl = tdsr_pkg::SIDE_LIMIT_RESET;
  logic [tdsr_pkg::STOP_W-1:0] rear_limit_lvl = tdsr_pkg::REAR_LIMIT_RESET;

  // Regulator state as the block should hold it: the base speed of the last
  // ready tick and the front readings stored at the last moving update.
  logic signed [tdsr_pkg::SPD_W-1:0] held_speed = '0;
  level_t                  last_front_left  = '0;
  level_t                  last_front_right = '0;

  tick_t      tick_q[$];      // ticks not yet handed to the driver
  motor_cmd_t cmd_q[$];       // commands owed by the block, oldest first
  int         ticks_in_flight = 0;  // queued but not yet transferred
  tick_t      cur_tick;

  // Traffic shaping, set per phase by the sequencing initial block.
  logic        bursty      = 1'b0;
  logic [15:0] stall_mask  = 16'hFFFF;
  logic [3:0]  stall_step  = '0;
  int          burst_left  = 0;
  int          gap_left    = 0;

  int ticks_sent    = 0;
  int cmds_seen     = 0;
  int cfg_writes    = 0;
  int settings_used = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;

  // Clamp an exact integer into the signed 16-bit speed range.
  function automatic logic signed [tdsr_pkg::SPD_W-1:0] clamp_speed(input longint v);
    if (v > longint'(tdsr_pkg::SPD_MAX)) return tdsr_pkg::SPD_MAX;
    if (v < longint'(tdsr_pkg::SPD_MIN)) return tdsr_pkg::SPD_MIN;
    return tdsr_pkg::SPD_W'(v);
  endfunction

  // Work out the command for one transferred tick and advance the state.
  // Base speed is kp * error / 2^frac, truncated toward zero and clamped.
  // While moving, the correction follows the larger front-diagonal reading,
  // with the sign and gain flipped for reverse, and it is dropped when it
  // would turn toward a side wall above the side limit.
  function automatic motor_cmd_t steer_command(input tick_t t);
    motor_cmd_t                        cmd;
    longint                            corr;
    longint                            d_left;
    longint                            d_right;
    logic signed [tdsr_pkg::SPD_W-1:0] c;
    cmd.motor_write = 1'b0;
    cmd.left_speed  = '0;
    cmd.right_speed = '0;
    if (t.sample_ready) begin
      corr    = 0;
      d_left  = longint'(t.front_left) - longint'(last_front_left);
      d_right = longint'(t.front_right) - longint'(last_front_right);
      held_speed = clamp_speed((longint'(kp_gain) * longint'(t.tilt_error)) /
                               (longint'(1) << ERROR_FRAC_BITS));
      if (held_speed > 0) begin
        if (t.front_left > t.front_right) corr = longint'(kd_fwd) * d_left;
        if (t.front_right > t.front_left) corr = -(longint'(kd_fwd) * d_right);
        last_front_left  = t.front_left;
        last_front_right = t.front_right;
        if (t.side_left > side_limit_lvl && corr < 0) corr = 0;
        if (t.side_right > side_limit_lvl && corr > 0) corr = 0;
      end else if (held_speed < 0) begin
        if (t.front_left > t.front_right) corr = -(longint'(kd_bwd) * d_left);
        if (t.front_right > t.front_left) corr = longint'(kd_bwd) * d_right;
        last_front_left  = t.front_left;
        last_front_right = t.front_right;
        if (t.side_left > side_limit_lvl && corr > 0) corr = 0;
        if (t.side_right > side_limit_lvl && corr < 0) corr = 0;
      end
      c = clamp_speed(corr);
      cmd.motor_write = 1'b1;
      cmd.left_speed  = tdsr_pkg::CMD_W'(int'(held_speed) + int'(c));
      cmd.right_speed = tdsr_pkg::CMD_W'(int'(held_speed) - int'(c));
    end
    // Rear wall with reverse motion stops both motors on any tick.
    if (t.back_left > rear_limit_lvl && t.back_right > rear_limit_lvl && held_speed < 0) begin
      cmd.motor_write = 1'b1;
      cmd.left_speed  = '0;
      cmd.right_speed = '0;
    end
    return cmd;
  endfunction

  function automatic level_t near_level(input int v);
    if (v < 0) return '0;
    if (v > (1 << SENSOR_BITS) - 1) return '1;
    return level_t'(v);
  endfunction

  function automatic tick_t fixed_tick(input logic rdy, input int tilt, input int fl,
                                       input int fr, input int sl, input int sr,
                                       input int bl, input int br);
    tick_t t;
    t.sample_ready = rdy;
    t.tilt_error   = tdsr_pkg::ERR_W'(tilt);
    t.front_left   = near_level(fl);
    t.front_right  = near_level(fr);
    t.side_left    = near_level(sl);
    t.side_right   = near_level(sr);
    t.back_left    = near_level(bl);
    t.back_right   = near_level(br);
    return t;
  endfunction

  // Random tick biased toward the interesting regions: small errors that
  // round to zero speed, equal or slowly changing front readings, and side
  // and rear readings straddling the current stop levels.
  function automatic tick_t random_tick();
    tick_t t;
    int    pick;
    t.sample_ready = ($urandom_range(0, 9) < 8);
    pick = $urandom_range(0, 9);
    if (pick < 4) t.tilt_error = tdsr_pkg::ERR_W'($urandom);
    else if (pick < 8) t.tilt_error = tdsr_pkg::ERR_W'(int'($urandom_range(0, 400)) - 200);
    else if (pick == 8) t.tilt_error = 16'sh7fff;
    else t.tilt_error = 16'sh8000;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      t.front_left  = level_t'($urandom);
      t.front_right = level_t'($urandom);
    end else if (pick < 7) begin
      t.front_left  = level_t'($urandom);
      t.front_right = t.front_left;
    end else begin
      t.front_left  = near_level(int'(last_front_left) + int'($urandom_range(0, 60)) - 30);
      t.front_right = near_level(int'(last_front_right) + int'($urandom_range(0, 60)) - 30);
    end
    if ($urandom_range(0, 1) == 0) begin
      t.side_left  = near_level(int'(side_limit_lvl) + int'($urandom_range(0, 6)) - 3);
      t.side_right = near_level(int'(side_limit_lvl) + int'($urandom_range(0, 6)) - 3);
    end else begin
      t.side_left  = level_t'($urandom);
      t.side_right = level_t'($urandom);
    end
    if ($urandom_range(0, 1) == 0) begin
      t.back_left  = near_level(int'(rear_limit_lvl) + int'($urandom_range(0, 6)) - 2);
      t.back_right = near_level(int'(rear_limit_lvl) + int'($urandom_range(0, 6)) - 2);
    end else begin
      t.back_left  = level_t'($urandom);
      t.back_right = level_t'($urandom);
    end
    return t;
  endfunction

  function automatic void queue_tick(input tick_t t);
    tick_q.push_back(t);
    ticks_in_flight++;
  endfunction

  // One configuration transfer. Valid stays high on return so that back to
  // back writes never drop it; end_writes lowers it after the last one.
  task automatic write_reg(input logic [tdsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tdsr_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_writes++;
    // Bits above each register's width are dropped; unknown indexes do nothing.
    case (idx)
      tdsr_pkg::REG_KP:         kp_gain        = data[tdsr_pkg::KP_W-1:0];
      tdsr_pkg::REG_KD_FWD:     kd_fwd         = data[tdsr_pkg::KD_W-1:0];
      tdsr_pkg::REG_KD_BWD:     kd_bwd         = data[tdsr_pkg::KD_W-1:0];
      tdsr_pkg::REG_SIDE_LIMIT: side_limit_lvl = data[tdsr_pkg::STOP_W-1:0];
      tdsr_pkg::REG_REAR_LIMIT: rear_limit_lvl = data[tdsr_pkg::STOP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Every tick yields exactly one command, so the block is idle once all
  // ticks have transferred and every owed command has come back.
  task automatic wait_until_drained();
    while (ticks_in_flight != 0 || cmd_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: presents ticks from tick_q, holding each one until it transfers.
  // In bursty phases a random gap follows each burst of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd_q.push_back(steer_command(cur_tick));
        ticks_in_flight--;
        ticks_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          cur_tick = tick_q.pop_front();
          in_ch.valid            <= 1'b1;
          in_ch.sample_ready     <= cur_tick.sample_ready;
          in_ch.tilt_error       <= cur_tick.tilt_error;
          in_ch.front_left_prox  <= cur_tick.front_left;
          in_ch.front_right_prox <= cur_tick.front_right;
          in_ch.left_prox        <= cur_tick.side_left;
          in_ch.right_prox       <= cur_tick.side_right;
          in_ch.back_left_prox   <= cur_tick.back_left;
          in_ch.back_right_prox  <= cur_tick.back_right;
          if (bursty) begin
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(0, 15);
              gap_left   = $urandom_range(1, 6);
            end
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel following a rotating 16-bit pattern and
  // checks each command that transfers against the oldest one owed.
  always @(posedge clk) begin
    motor_cmd_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        cmds_seen++;
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Command %0d arrived with none owed: write=%0b left=%0d right=%0d",
                     cmds_seen, out_ch.motor_write, out_ch.left_speed, out_ch.right_speed);
        end else begin
          want = cmd_q.pop_front();
          if (want.motor_write !== out_ch.motor_write ||
              want.left_speed !== out_ch.left_speed ||
              want.right_speed !== out_ch.right_speed) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("Command %0d differs: expected write=%0b left=%0d right=%0d, %s%0b %s%0d %s%0d",
                       cmds_seen, want.motor_write, want.left_speed, want.right_speed,
                       "got write=", out_ch.motor_write, "left=", out_ch.left_speed,
                       "right=", out_ch.right_speed);
          end
        end
      end
      out_ch.ready <= stall_mask[stall_step];
      stall_step   <= stall_step + 4'd1;
    end
  end

  // Watchdog: a run of cycles with no transfer on any channel means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sequencer: reset, a directed part at reset settings, a directed part at
  // saturating settings, then random phases, each under its own settings and
  // its own traffic shape. Registers are only written while the block is idle.
  initial begin
    logic [tdsr_pkg::CFG_DATA_W-1:0] kp_w;
    logic [tdsr_pkg::CFG_DATA_W-1:0] kdf_w;
    logic [tdsr_pkg::CFG_DATA_W-1:0] kdb_w;
    logic [tdsr_pkg::CFG_DATA_W-1:0] side_w;
    logic [tdsr_pkg::CFG_DATA_W-1:0] back_w;
    in_ch.valid            = 1'b0;
    in_ch.sample_ready     = 1'b0;
    in_ch.tilt_error       = '0;
    in_ch.front_left_prox  = '0;
    in_ch.front_right_prox = '0;
    in_ch.left_prox        = '0;
    in_ch.right_prox       = '0;
    in_ch.back_left_prox   = '0;
    in_ch.back_right_prox  = '0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.wdata           = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at reset settings (kp 2000, kd 1 and 2, side 300, rear 40).
    queue_tick(fixed_tick(1'b0, 0, 0, 0, 0, 0, 0, 0));              // idle tick
    queue_tick(fixed_tick(1'b1, 0, 100, 200, 0, 0, 0, 0));          // zero speed, fronts kept
    queue_tick(fixed_tick(1'b1, 32767, 4095, 0, 0, 0, 0, 0));       // forward, left larger
    queue_tick(fixed_tick(1'b1, 32767, 4095, 4095, 0, 0, 0, 0));    // equal fronts, stored
    queue_tick(fixed_tick(1'b1, 32767, 10, 3000, 0, 4095, 0, 0));   // right wall blocks turn
    queue_tick(fixed_tick(1'b1, 32767, 4000, 100, 4095, 0, 0, 0));  // turn away from left wall
    queue_tick(fixed_tick(1'b1, 32767, 200, 100, 4095, 0, 0, 0));   // left wall blocks turn
    queue_tick(fixed_tick(1'b1, -32768, 4095, 0, 0, 4095, 0, 0));   // reverse, right wall blocks
    queue_tick(fixed_tick(1'b1, -32768, 0, 4095, 0, 0, 0, 0));      // reverse, right larger
    queue_tick(fixed_tick(1'b0, 0, 0, 0, 0, 0, 4095, 4095));        // rear stop on idle tick
    queue_tick(fixed_tick(1'b1, -5000, 50, 60, 0, 0, 41, 41));      // rear stop on ready tick
    queue_tick(fixed_tick(1'b1, -5000, 50, 60, 0, 0, 4095, 40));    // one rear sensor only
    queue_tick(fixed_tick(1'b0, 1234, 9, 9, 9, 9, 0, 0));           // idle, no rear wall
    queue_tick(fixed_tick(1'b1, 2, 300, 200, 0, 0, 0, 0));          // rounds to zero speed
    queue_tick(fixed_tick(1'b1, -3, 300, 200, 0, 0, 0, 0));         // truncates to -1
    queue_tick(fixed_tick(1'b1, 3, 200, 300, 0, 0, 0, 0));          // truncates to +1
    wait_until_drained();

    // Directed ticks at saturating gains; the upper write-data bits must be dropped.
    write_reg(tdsr_pkg::REG_KP, 16'hFFFF);
    write_reg(tdsr_pkg::REG_KD_FWD, 16'hFFFF);
    write_reg(tdsr_pkg::REG_KD_BWD, 16'hFFF5);
    write_reg(tdsr_pkg::REG_KD_BWD, 16'h00FF);
    write_reg(tdsr_pkg::REG_SIDE_LIMIT, 16'hFFFF);
    write_reg(tdsr_pkg::REG_REAR_LIMIT, 16'hF000);
    end_writes();
    queue_tick(fixed_tick(1'b1, 32767, 0, 0, 0, 0, 0, 0));
    queue_tick(fixed_tick(1'b1, 32767, 4095, 0, 0, 0, 0, 0));       // both clamps hit, left max
    queue_tick(fixed_tick(1'b1, 32767, 0, 0, 0, 0, 0, 0));
    queue_tick(fixed_tick(1'b1, -32768, 4095, 0, 0, 0, 0, 0));      // left at the 17-bit minimum
    queue_tick(fixed_tick(1'b0, 0, 0, 0, 0, 0, 1, 1));              // rear stop at level zero
    queue_tick(fixed_tick(1'b1, -32768, 0, 4095, 4095, 4095, 0, 0));
    wait_until_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          kp_w = 16'hFFFF; kdf_w = 16'hFFFF; kdb_w = 16'hFFFF;
          side_w = 16'hFFFF; back_w = 16'hFFFF;
        end
        1: begin
          kp_w = 16'h0000; kdf_w = 16'h0000; kdb_w = 16'h0000;
          side_w = 16'h0000; back_w = 16'h0000;
        end
        3: begin
          kp_w = 16'(tdsr_pkg::KP_RESET); kdf_w = 16'(tdsr_pkg::KD_FWD_RESET);
          kdb_w = 16'(tdsr_pkg::KD_BWD_RESET);
          side_w = 16'(tdsr_pkg::SIDE_LIMIT_RESET); back_w = 16'(tdsr_pkg::REAR_LIMIT_RESET);
        end
        4: begin
          // Small gain: many ticks land on zero or tiny speeds.
          kp_w = 16'($urandom_range(1, 200)); kdf_w = 16'($urandom); kdb_w = 16'($urandom);
          side_w = 16'($urandom_range(0, 4095)); back_w = 16'($urandom_range(0, 300));
        end
        default: begin
          kp_w = 16'($urandom); kdf_w = 16'($urandom); kdb_w = 16'($urandom);
          side_w = 16'($urandom_range(0, 4095)); back_w = 16'($urandom_range(0, 300));
        end
      endcase
      write_reg(tdsr_pkg::REG_KP, kp_w);
      write_reg(tdsr_pkg::REG_KD_FWD, kdf_w);
      write_reg(tdsr_pkg::REG_KD_BWD, kdb_w);
      write_reg(tdsr_pkg::REG_SIDE_LIMIT, side_w);
      // An index beyond the register list must leave every register untouched.
      write_reg(tdsr_pkg::CFG_IDX_W'($urandom_range(5, 7)), 16'($urandom));
      write_reg(tdsr_pkg::REG_REAR_LIMIT, back_w);
      end_writes();

      // Phases 0 and 4 run with no idling on either side.
      bursty     = (p % 4 != 0);
      burst_left = 0;
      gap_left   = 0;
      stall_mask = (p % 4 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
      repeat (TICKS_PER_PHASE) queue_tick(random_tick());
      wait_until_drained();
    end

    $display("Covered %0d ticks and %0d motor commands under %0d register settings (%0d writes).",
             ticks_sent, cmds_seen, settings_used, cfg_writes);
    $display("Mismatched or unowed commands: %0d; commands still owed: %0d.",
             mismatches, cmd_q.size());
    if (mismatches == 0 && cmd_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
